// ===== hw/rtl/cdr_pkg.sv =====
// Shared constants, register codes and byte-mapping functions for the DNS responder.
package cdr_pkg;

    // Largest datagram that is stored; later bytes are ignored
    localparam int MAX_DATAGRAM = 512;

    // Byte offset width: holds 0 .. MAX_DATAGRAM
    localparam int IDX_W = $clog2(MAX_DATAGRAM + 1);
    // Label offset width: holds a jump of up to 256 past the last stored offset
    localparam int LBL_W = $clog2(MAX_DATAGRAM + 257);

    localparam int HDR_LEN   = 12;
    localparam int QTAIL_LEN = 5;   // terminator plus QTYPE and QCLASS
    localparam int REC_LEN   = 16;
    localparam int REC_CNT_W = $clog2(REC_LEN + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ANSWER_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANSWER_TTL     = 2'd1;

    localparam logic [31:0] ANSWER_ADDRESS_RST = 32'hC0A8_2A01;
    localparam logic [31:0] ANSWER_TTL_RST     = 32'd60;

    // Header flags that the reply rewrites, and the name pointer of the appended record
    localparam logic [7:0] FLAGS_HI  = 8'h81;
    localparam logic [7:0] FLAGS_LO  = 8'h80;
    localparam logic [7:0] NAME_PTR_HI = 8'hC0;
    localparam logic [7:0] NAME_PTR_LO = 8'h0C;

    // Rewrite one header byte of the query into the reply
    function automatic logic [7:0] header_byte(input logic [IDX_W-1:0] idx,
                                               input logic [7:0] b);
        logic [7:0] r;
        begin
            unique case (idx)
                IDX_W'(2):  r = FLAGS_HI;
                IDX_W'(3):  r = FLAGS_LO;
                IDX_W'(7):  r = 8'd1;
                IDX_W'(6),
                IDX_W'(8),
                IDX_W'(9),
                IDX_W'(10),
                IDX_W'(11): r = 8'd0;
                default:    r = b;
            endcase
            return r;
        end
    endfunction

    // Byte i of the appended A record
    function automatic logic [7:0] record_byte(input logic [3:0] i,
                                               input logic [31:0] ttl,
                                               input logic [31:0] addr);
        logic [7:0] r;
        begin
            unique case (i)
                4'd0:    r = NAME_PTR_HI;
                4'd1:    r = NAME_PTR_LO;
                4'd2:    r = 8'd0;
                4'd3:    r = 8'd1;
                4'd4:    r = 8'd0;
                4'd5:    r = 8'd1;
                4'd6:    r = ttl[31:24];
                4'd7:    r = ttl[23:16];
                4'd8:    r = ttl[15:8];
                4'd9:    r = ttl[7:0];
                4'd10:   r = 8'd0;
                4'd11:   r = 8'd4;
                4'd12:   r = addr[31:24];
                4'd13:   r = addr[23:16];
                4'd14:   r = addr[15:8];
                default: r = addr[7:0];
            endcase
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/cdr_if.sv =====
// Handshake channel interfaces: query bytes in, reply items out, register writes.
interface cdr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;

    modport source (output valid, output rx_byte, output last_byte, input ready);
    modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface cdr_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_byte_valid;
    logic       packet_end;
    logic       keep_packet;

    modport source (output valid, output tx_byte, output tx_byte_valid,
                    output packet_end, output keep_packet, input ready);
    modport sink   (input valid, input tx_byte, input tx_byte_valid,
                    input packet_end, input keep_packet, output ready);
endinterface

interface cdr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cdr_pkg::CFG_IDX_W-1:0]  index;
    logic [31:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/captive_dns_responder_top.sv =====
// Captive-portal DNS responder: rewrites a query stream into an A-record reply.
//
//  channel | dir | payload                                          | accepted when
//  rx      | in  | rx_byte, last_byte                               | valid & ready
//  tx      | out | tx_byte, tx_byte_valid, packet_end, keep_packet  | valid & ready
//  cfg     | in  | index, data (0 answer_address, 1 answer_ttl)     | valid & ready
//
//  One query byte per cycle: each byte goes through the label walker and lands in
//  the output register in the cycle it is accepted, so the next byte may follow.
//  The byte that completes QCLASS adds a 16-item record tail if it fits in the
//  datagram; the tail counter holds rx off until those items are loaded.
//  Reset clears the walker, the tail counter and the output valid; registers
//  return to 192.168.42.1 and TTL 60. A stalled tx holds rx as well.
module captive_dns_responder_top (
    input  logic            clk,
    input  logic            rst_n,
    cdr_rx_if.sink          rx,
    cdr_tx_if.source        tx,
    cdr_cfg_if.sink         cfg
);

    // Configuration registers
    logic [31:0] answer_address_reg;
    logic [31:0] answer_ttl_reg;

    // Walker state
    logic [cdr_pkg::IDX_W-1:0] byte_index_reg;
    logic [cdr_pkg::LBL_W-1:0] next_label_reg;
    logic [cdr_pkg::LBL_W-1:0] question_end_reg;
    logic                      term_seen_reg;

    // Output register and record tail
    logic                          out_valid_reg;
    logic [7:0]                    out_byte_reg;
    logic                          out_byte_valid_reg;
    logic                          out_end_reg;
    logic                          out_keep_reg;
    logic [cdr_pkg::REC_CNT_W-1:0] rec_left_reg;
    logic                          rec_end_reg;
    logic                          rec_keep_reg;

    logic                          out_free;
    logic                          rx_fire;
    logic                          tail_load;
    logic [3:0]                    rec_pos;

    logic [cdr_pkg::IDX_W-1:0]     idx;
    logic [cdr_pkg::LBL_W-1:0]     idx_ext;
    logic                          stored;
    logic                          at_label;
    logic                          term_next;
    logic [cdr_pkg::LBL_W-1:0]     question_end_next;
    logic [cdr_pkg::LBL_W-1:0]     next_label_next;
    logic [cdr_pkg::IDX_W-1:0]     byte_index_next;
    logic                          fits;
    logic                          emit;
    logic                          append;
    logic                          keep;
    logic                          item_out;

    // Handshakes
    assign out_free  = !out_valid_reg || tx.ready;
    assign rx.ready  = (rec_left_reg == '0) && out_free;
    assign rx_fire   = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;
    assign tail_load = (rec_left_reg != '0) && out_free;
    assign rec_pos   = 4'(cdr_pkg::REC_CNT_W'(cdr_pkg::REC_LEN) - rec_left_reg);

    // Label walker for the byte at the input
    always_comb
    begin
        idx       = byte_index_reg;
        idx_ext   = cdr_pkg::LBL_W'(byte_index_reg);
        stored    = byte_index_reg < cdr_pkg::IDX_W'(cdr_pkg::MAX_DATAGRAM);
        at_label  = stored && (idx >= cdr_pkg::IDX_W'(cdr_pkg::HDR_LEN)) &&
                    !term_seen_reg && (idx_ext == next_label_reg);
        term_next = term_seen_reg || (at_label && (rx.rx_byte == 8'd0));
        question_end_next = (at_label && (rx.rx_byte == 8'd0)) ?
                            idx_ext + cdr_pkg::LBL_W'(cdr_pkg::QTAIL_LEN) : question_end_reg;
        next_label_next   = (at_label && (rx.rx_byte != 8'd0)) ?
                            idx_ext + cdr_pkg::LBL_W'(rx.rx_byte) + cdr_pkg::LBL_W'(1) :
                            next_label_reg;
        byte_index_next   = stored ? idx + cdr_pkg::IDX_W'(1) : idx;
        fits   = ({1'b0, question_end_next} + (cdr_pkg::LBL_W+1)'(cdr_pkg::REC_LEN)) <=
                 (cdr_pkg::LBL_W+1)'(cdr_pkg::MAX_DATAGRAM);
        emit   = stored && !(term_next && (idx_ext >= question_end_next));
        append = stored && term_next && fits &&
                 ((idx_ext + cdr_pkg::LBL_W'(1)) == question_end_next);
        keep   = (byte_index_next >= cdr_pkg::IDX_W'(cdr_pkg::HDR_LEN)) && term_next &&
                 (question_end_next <= cdr_pkg::LBL_W'(byte_index_next)) && fits;
        item_out = emit || rx.last_byte;
    end

    // Configuration writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            answer_address_reg <= cdr_pkg::ANSWER_ADDRESS_RST;
            answer_ttl_reg     <= cdr_pkg::ANSWER_TTL_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == cdr_pkg::REG_ANSWER_ADDRESS)
            begin
                answer_address_reg <= cfg.data;
            end
            if (cfg.index == cdr_pkg::REG_ANSWER_TTL)
            begin
                answer_ttl_reg <= cfg.data;
            end
        end
    end

    // Advance the walker; clear it after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg   <= '0;
            next_label_reg   <= cdr_pkg::LBL_W'(cdr_pkg::HDR_LEN);
            question_end_reg <= '0;
            term_seen_reg    <= 1'b0;
        end
        else if (rx_fire)
        begin
            if (rx.last_byte)
            begin
                byte_index_reg   <= '0;
                next_label_reg   <= cdr_pkg::LBL_W'(cdr_pkg::HDR_LEN);
                question_end_reg <= '0;
                term_seen_reg    <= 1'b0;
            end
            else
            begin
                byte_index_reg   <= byte_index_next;
                next_label_reg   <= next_label_next;
                question_end_reg <= question_end_next;
                term_seen_reg    <= term_next;
            end
        end
    end

    // Output control: load a query byte, step the record tail, or drain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rec_left_reg  <= '0;
        end
        else if (rx_fire && item_out)
        begin
            out_valid_reg <= 1'b1;
            if (append)
            begin
                rec_left_reg <= cdr_pkg::REC_CNT_W'(cdr_pkg::REC_LEN);
            end
        end
        else if (tail_load)
        begin
            out_valid_reg <= 1'b1;
            rec_left_reg  <= rec_left_reg - cdr_pkg::REC_CNT_W'(1);
        end
        else if (tx.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (rx_fire && item_out)
        begin
            out_byte_reg       <= emit ? cdr_pkg::header_byte(idx, rx.rx_byte) : 8'd0;
            out_byte_valid_reg <= emit;
            out_end_reg        <= rx.last_byte && !append;
            out_keep_reg       <= rx.last_byte && !append && keep;
            rec_end_reg        <= rx.last_byte;
            rec_keep_reg       <= keep;
        end
        else if (tail_load)
        begin
            out_byte_reg       <= cdr_pkg::record_byte(rec_pos, answer_ttl_reg,
                                                       answer_address_reg);
            out_byte_valid_reg <= 1'b1;
            out_end_reg        <= (rec_left_reg == cdr_pkg::REC_CNT_W'(1)) && rec_end_reg;
            out_keep_reg       <= (rec_left_reg == cdr_pkg::REC_CNT_W'(1)) && rec_end_reg &&
                                  rec_keep_reg;
        end
    end

    assign tx.valid         = out_valid_reg;
    assign tx.tx_byte       = out_byte_reg;
    assign tx.tx_byte_valid = out_byte_valid_reg;
    assign tx.packet_end    = out_end_reg;
    assign tx.keep_packet   = out_keep_reg;

    // A pending record tail always has an item on display
    a_tail_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_left_reg != '0) |-> out_valid_reg)
        else $error("record tail pending without output item");

    // A verdict-only item carries a zero byte and ends the datagram
    a_verdict_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_byte_valid_reg) |-> (out_byte_reg == 8'd0 && out_end_reg))
        else $error("byte-less item that is not a verdict");

    // Keep is only given with the end of a datagram
    a_keep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_keep_reg) |-> out_end_reg)
        else $error("keep without packet end");

    // Each taken record byte steps the tail by one
    a_tail_step: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_left_reg != '0 && tx.ready) |=>
        (rec_left_reg == $past(rec_left_reg) - cdr_pkg::REC_CNT_W'(1)))
        else $error("record tail count skipped");

endmodule
